@@ rtl/core/tks_pkg.sv @@
// token scanner package: sizes, codes, result types and character tables
`timescale 1ns / 1ps

package tks_pkg;

  localparam int unsigned POS_BITS  = 32;
  localparam int unsigned LEN_BITS  = 16;
  localparam int unsigned KIND_BITS = 5;
  localparam int unsigned ERR_BITS  = 2;
  localparam int unsigned CHAR_BITS = 8;

  // m-side tdata: start, length, error kind, bad byte, padded to whole bytes
  localparam int unsigned OUT_FIELD_BITS = POS_BITS + LEN_BITS + ERR_BITS + CHAR_BITS;
  localparam int unsigned OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned KW_LEN = 6;

  // token kinds
  localparam logic [KIND_BITS-1:0] KIND_END    = 5'd0;
  localparam logic [KIND_BITS-1:0] KIND_IDENT  = 5'd1;
  localparam logic [KIND_BITS-1:0] KIND_RETURN = 5'd2;
  localparam logic [KIND_BITS-1:0] KIND_DOUBLE = 5'd3;
  localparam logic [KIND_BITS-1:0] KIND_SYM0   = 5'd4;
  localparam logic [KIND_BITS-1:0] KIND_ERROR  = 5'd16;

  // error kinds
  localparam logic [ERR_BITS-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_UNKNOWN   = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_NO_POINT  = 2'd2;
  localparam logic [ERR_BITS-1:0] ERR_NO_DIGIT  = 2'd3;

  // character codes
  localparam logic [CHAR_BITS-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_ALL1  = 8'hFF;
  localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_UNDER = 8'h5F;
  localparam logic [CHAR_BITS-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_LC_Z  = 8'h7A;
  localparam logic [CHAR_BITS-1:0] CH_UC_A  = 8'h41;
  localparam logic [CHAR_BITS-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CH_D0    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_D9    = 8'h39;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_INT,
    MODE_POINT,
    MODE_FRAC,
    MODE_DRAIN
  } tks_mode_e;

  typedef struct packed {
    logic       is_end;
    logic       is_space;
    logic       is_letter;
    logic       is_digit;
    logic       is_under;
    logic       is_point;
    logic       is_sym;
    logic [3:0] sym_idx;
  } tks_class_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [POS_BITS-1:0]  start;
    logic [LEN_BITS-1:0]  length;
    logic [ERR_BITS-1:0]  err;
    logic [CHAR_BITS-1:0] bad;
    logic                 last;
  } tks_res_t;

  // up to two result words from one accepted byte
  typedef struct packed {
    logic [1:0] cnt;
    tks_res_t   a;
    tks_res_t   b;
  } tks_push_t;

  // letters of the return keyword
  function automatic logic [CHAR_BITS-1:0] kw_char(input logic [2:0] idx);
    logic [CHAR_BITS-1:0] c;
    case (idx)
      3'd0:    c = 8'h72;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h75;
      3'd4:    c = 8'h72;
      3'd5:    c = 8'h6E;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  // symbol index in token order, bit 4 set on a hit
  function automatic logic [4:0] sym_lookup(input logic [CHAR_BITS-1:0] c);
    logic [4:0] r;
    case (c)
      8'h28:   r = {1'b1, 4'd0};
      8'h29:   r = {1'b1, 4'd1};
      8'h7B:   r = {1'b1, 4'd2};
      8'h7D:   r = {1'b1, 4'd3};
      8'h2C:   r = {1'b1, 4'd4};
      8'h3B:   r = {1'b1, 4'd5};
      8'h3D:   r = {1'b1, 4'd6};
      8'h2B:   r = {1'b1, 4'd7};
      8'h2D:   r = {1'b1, 4'd8};
      8'h2A:   r = {1'b1, 4'd9};
      8'h2F:   r = {1'b1, 4'd10};
      8'h25:   r = {1'b1, 4'd11};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/tks_char_class.sv @@
// byte classifier for the token scanner
`timescale 1ns / 1ps

module tks_char_class import tks_pkg::*; (
  input  logic [CHAR_BITS-1:0] char_i,
  output tks_class_t           class_o
);

  logic [4:0] sym;

  assign sym = sym_lookup(char_i);

  always_comb begin
    class_o.is_end    = (char_i == CH_NUL) || (char_i == CH_ALL1);
    class_o.is_space  = (char_i == CH_SPACE) || ((char_i >= CH_TAB) && (char_i <= CH_CR));
    class_o.is_letter = ((char_i >= CH_LC_A) && (char_i <= CH_LC_Z)) ||
                        ((char_i >= CH_UC_A) && (char_i <= CH_UC_Z));
    class_o.is_digit  = (char_i >= CH_D0) && (char_i <= CH_D9);
    class_o.is_under  = (char_i == CH_UNDER);
    class_o.is_point  = (char_i == CH_POINT);
    class_o.is_sym    = sym[4];
    class_o.sym_idx   = sym[3:0];
  end

endmodule

@@ rtl/core/tks_scan_fsm.sv @@
// scan state machine: per-byte mode, run tracking and result words
`timescale 1ns / 1ps

module tks_scan_fsm import tks_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [CHAR_BITS-1:0] char_i,
  input  tks_class_t           class_i,
  output tks_push_t            push_o
);

  tks_mode_e            mode_q, mode_d;
  logic                 kw_q, kw_d;
  logic [POS_BITS-1:0]  start_q, start_d;
  logic [LEN_BITS-1:0]  len_q, len_d;
  logic [POS_BITS-1:0]  pos_q, pos_d;

  // fresh scan of the current byte
  tks_mode_e            f_mode;
  logic                 f_begin;
  logic                 f_emit;
  logic                 f_restart;
  tks_res_t             f_res;

  logic [LEN_BITS-1:0]  len_inc;
  logic                 restart;
  tks_res_t             run_res;
  tks_res_t             err_res;
  logic [1:0]           cnt;
  tks_res_t             res_a, res_b;

  assign len_inc = (len_q == {LEN_BITS{1'b1}}) ? len_q : len_q + 1'b1;

  always_comb begin
    f_mode       = MODE_IDLE;
    f_begin      = 1'b0;
    f_emit       = 1'b0;
    f_restart    = 1'b0;
    f_res.kind   = KIND_END;
    f_res.start  = pos_q;
    f_res.length = LEN_BITS'(1);
    f_res.err    = ERR_NONE;
    f_res.bad    = CH_NUL;
    f_res.last   = 1'b0;
    if (class_i.is_end) begin
      f_emit    = 1'b1;
      f_restart = 1'b1;
    end else if (class_i.is_space) begin
      f_mode = MODE_IDLE;
    end else if (class_i.is_letter) begin
      f_mode  = MODE_WORD;
      f_begin = 1'b1;
    end else if (class_i.is_digit) begin
      f_mode  = MODE_INT;
      f_begin = 1'b1;
    end else if (class_i.is_sym) begin
      f_emit     = 1'b1;
      f_res.kind = KIND_SYM0 + {1'b0, class_i.sym_idx};
    end else begin
      f_mode     = MODE_DRAIN;
      f_emit     = 1'b1;
      f_res.kind = KIND_ERROR;
      f_res.err  = ERR_UNKNOWN;
      f_res.bad  = char_i;
    end
  end

  always_comb begin
    mode_d         = mode_q;
    kw_d           = kw_q;
    start_d        = start_q;
    len_d          = len_q;
    restart        = 1'b0;
    cnt            = 2'd0;

    run_res.kind   = KIND_IDENT;
    run_res.start  = start_q;
    run_res.length = len_q;
    run_res.err    = ERR_NONE;
    run_res.bad    = CH_NUL;
    run_res.last   = 1'b0;

    err_res        = f_res;
    err_res.kind   = KIND_ERROR;
    err_res.err    = (mode_q == MODE_POINT) ? ERR_NO_DIGIT : ERR_NO_POINT;
    err_res.bad    = char_i;

    res_a          = f_res;
    res_b          = f_res;

    case (mode_q)
      MODE_WORD: begin
        if (class_i.is_letter || class_i.is_digit || class_i.is_under) begin
          kw_d  = kw_q && (len_q < LEN_BITS'(KW_LEN)) && (char_i == kw_char(len_q[2:0]));
          len_d = len_inc;
        end else begin
          run_res.kind = (kw_q && (len_q == LEN_BITS'(KW_LEN))) ? KIND_RETURN : KIND_IDENT;
          res_a        = run_res;
          cnt          = f_emit ? 2'd2 : 2'd1;
          mode_d       = f_mode;
          restart      = f_restart;
          kw_d         = 1'b0;
        end
      end
      MODE_INT: begin
        if (class_i.is_digit) begin
          len_d = len_inc;
        end else if (class_i.is_point) begin
          len_d  = len_inc;
          mode_d = MODE_POINT;
        end else begin
          res_a   = err_res;
          cnt     = 2'd1;
          mode_d  = class_i.is_end ? MODE_IDLE : MODE_DRAIN;
          restart = class_i.is_end;
        end
      end
      MODE_POINT: begin
        if (class_i.is_digit) begin
          len_d  = len_inc;
          mode_d = MODE_FRAC;
        end else begin
          res_a   = err_res;
          cnt     = 2'd1;
          mode_d  = class_i.is_end ? MODE_IDLE : MODE_DRAIN;
          restart = class_i.is_end;
        end
      end
      MODE_FRAC: begin
        if (class_i.is_digit) begin
          len_d = len_inc;
        end else begin
          run_res.kind = KIND_DOUBLE;
          res_a        = run_res;
          cnt          = f_emit ? 2'd2 : 2'd1;
          mode_d       = f_mode;
          restart      = f_restart;
        end
      end
      MODE_DRAIN: begin
        if (class_i.is_end) begin
          mode_d  = MODE_IDLE;
          restart = 1'b1;
        end
      end
      default: begin
        cnt     = f_emit ? 2'd1 : 2'd0;
        mode_d  = f_mode;
        restart = f_restart;
      end
    endcase

    // a word or literal starting on this byte, from idle or on the byte ending a run
    if (f_begin && (mode_q == MODE_IDLE ||
        (mode_q == MODE_WORD && !(class_i.is_letter || class_i.is_digit || class_i.is_under)) ||
        (mode_q == MODE_FRAC && !class_i.is_digit))) begin
      start_d = pos_q;
      len_d   = LEN_BITS'(1);
      if (class_i.is_letter) begin
        kw_d = (char_i == kw_char(3'd0));
      end
    end

    pos_d = restart ? '0 : pos_q + 1'b1;

    if (cnt == 2'd2) begin
      res_b.last = 1'b1;
    end else begin
      res_a.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      kw_q    <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      kw_q    <= kw_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

  always_comb begin
    push_o.cnt = fire_i ? cnt : 2'd0;
    push_o.a   = res_a;
    push_o.b   = res_b;
  end

endmodule

@@ rtl/core/tks_res_fifo.sv @@
// result queue: takes up to two words per cycle, hands out one
`timescale 1ns / 1ps

module tks_res_fifo import tks_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tks_push_t push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tks_res_t  out_res_o
);

  tks_res_t                ent_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   cnt_q, cnt_d;
  logic [FIFO_PTR_W-1:0]   wr_ptr_nx;
  logic                    pop;

  // room for a byte that gives two words
  assign room_o      = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign out_res_o   = ent_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_nx = FIFO_PTR_W'(wr_ptr_q + 1'b1);
    wr_ptr_d  = FIFO_PTR_W'(wr_ptr_q + push_i.cnt);
    rd_ptr_d  = FIFO_PTR_W'(rd_ptr_q + pop);
    cnt_d     = FIFO_CNT_W'(cnt_q + FIFO_CNT_W'(push_i.cnt) - FIFO_CNT_W'(pop));
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      ent_q[wr_ptr_q] <= push_i.a;
    end
    if (push_i.cnt == 2'd2) begin
      ent_q[wr_ptr_nx] <= push_i.b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ rtl/core/token_scanner.sv @@
// token scanner top level: byte stream in, token stream out
//
//   channel   dir  width       carries
//   s_axis    in   8           one source byte per word
//   m_axis    out  64 + 5 + 1  token start, length, error, bad byte; kind; last
//
// each accepted byte is scanned in the cycle it is taken; its zero, one or two
// token words are registered into a four-word result queue that feeds m_axis
// a byte is taken every cycle while the queue has room for two words
// m_axis stalls back up into s_axis only once the queue holds three words
// reset clears scan mode, run tracking, byte position and queue pointers; no clearing pass
module token_scanner import tks_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [CHAR_BITS-1:0]   s_axis_tdata,   // in_char
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // token_start, token_length, error_kind, bad_char, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [KIND_BITS-1:0]   m_axis_tuser,   // token_kind
  output logic                   m_axis_tlast    // last_of_run
);

  tks_class_t cls;
  tks_push_t  push;
  tks_res_t   res;
  logic       room;
  logic       fire;

  assign s_axis_tready = room;
  assign fire          = s_axis_tvalid && room;

  tks_char_class u_class (
    .char_i  (s_axis_tdata),
    .class_o (cls)
  );

  tks_scan_fsm u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .char_i  (s_axis_tdata),
    .class_i (cls),
    .push_o  (push)
  );

  tks_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res)
  );

  assign m_axis_tdata = OUT_TDATA_W'({res.bad, res.err, res.length, res.start});
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
